FILE: rtl/interrupt_mask_pending_dispatcher_unit_assert.svh
// Assertion macros shared by the dispatcher RTL
`ifndef INTERRUPT_MASK_PENDING_DISPATCHER_UNIT_ASSERT_SVH
`define INTERRUPT_MASK_PENDING_DISPATCHER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define IMPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define IMPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/impd_pkg.sv
`default_nettype none

package impd_pkg;

  // Request codes of an input word
  localparam logic [3:0] REQ_RAISE    = 4'd0;
  localparam logic [3:0] REQ_SET_PEND = 4'd1;
  localparam logic [3:0] REQ_CLR_PEND = 4'd2;
  localparam logic [3:0] REQ_MASK     = 4'd3;
  localparam logic [3:0] REQ_UNMASK   = 4'd4;
  localparam logic [3:0] REQ_CLR_ALL  = 4'd5;
  localparam logic [3:0] REQ_GDISABLE = 4'd6;
  localparam logic [3:0] REQ_GENABLE  = 4'd7;
  localparam logic [3:0] REQ_STATUS   = 4'd8;

  // Classified command as queued between front and back
  typedef struct packed {
    logic [3:0] op;
    logic       scan;
    logic [4:0] line;
  } cmd_t;

  // Head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // Index of the lowest set bit, zero when none is set
  function automatic logic [5:0] lowest_set(input logic [63:0] v);
    logic [5:0] idx;
    idx = 6'd0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) idx = 6'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/impd_front.sv
`default_nettype none

module impd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [3:0]      req_type,
  input  wire logic [4:0]      line,
  input  wire logic            pop,
  output logic                 busy,
  output impd_pkg::q_head_t    head
);

`include "interrupt_mask_pending_dispatcher_unit_assert.svh"

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);

  impd_pkg::cmd_t     q [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;
  impd_pkg::cmd_t     cmd_in;
  logic               push;

  // Classify the incoming word: unknown codes fold into status
  always_comb begin
    cmd_in.line = line;
    cmd_in.op   = (req_type > impd_pkg::REQ_STATUS) ? impd_pkg::REQ_STATUS : req_type;
    cmd_in.scan = (req_type == impd_pkg::REQ_SET_PEND) ||
                  (req_type == impd_pkg::REQ_UNMASK) ||
                  (req_type == impd_pkg::REQ_GENABLE);
  end

  assign busy = (count == (PTR_W+1)'(QDEPTH));
  assign push = start && !busy;

  assign head.valid = (count != '0);
  assign head.cmd   = q[rd_ptr];

  // Store accepted words
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cmd_in;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  `IMPD_ASSERT_NOW(a_pop_nonempty, clk, rst, pop, count != '0, "pop from empty queue")

endmodule

`default_nettype wire

FILE: rtl/impd_back.sv
`default_nettype none

module impd_back #(
  parameter int LINE_COUNT = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [31:0]      claimed_lines,
  input  wire impd_pkg::q_head_t head,
  output logic                  pop,
  output logic                  done,
  output logic                  dispatch_valid,
  output logic [4:0]            dispatched_line,
  output logic                  pending_any,
  output logic [4:0]            next_pending_line,
  output logic                  line_enabled,
  output logic                  global_enabled,
  output logic                  last
);

`include "interrupt_mask_pending_dispatcher_unit_assert.svh"

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic                  state;
  logic [LINE_COUNT-1:0] mask;
  logic [LINE_COUNT-1:0] pend;
  logic                  gen;
  logic [LINE_COUNT-1:0] rem;
  logic                  st_pany;
  logic [4:0]            st_next;
  logic                  st_len;

  logic [LINE_COUNT-1:0] claimed_v;
  logic [LINE_COUNT-1:0] lb;
  logic [LINE_COUNT-1:0] mask_next;
  logic [LINE_COUNT-1:0] pend_next;
  logic                  gen_next;
  logic [LINE_COUNT-1:0] disp_next;
  logic [LINE_COUNT-1:0] hit;
  logic [LINE_COUNT-1:0] rem_clr;
  logic [5:0]            lo;
  logic [5:0]            pend_lo;
  logic                  load;

  // Claim bits exist only for the first 32 lines
  always_comb begin
    for (int i = 0; i < LINE_COUNT; i++) begin
      claimed_v[i] = (i < 32) ? claimed_lines[5'(i)] : 1'b0;
    end
  end

  // Decode the requested line, dropping lines beyond the controller
  assign lb = (32'(head.cmd.line) < LINE_COUNT) ? (LINE_COUNT'(1) << head.cmd.line) : '0;

  // Work out the whole step at once: new state and the set of lines to dispatch
  always_comb begin
    mask_next = mask;
    pend_next = pend;
    gen_next  = gen;
    disp_next = '0;
    hit       = '0;
    case (head.cmd.op)
      impd_pkg::REQ_RAISE: begin
        if (lb != '0 && (pend & lb) == '0) begin
          if ((mask & lb) != '0 || !gen) pend_next = pend | lb;
          else                           disp_next = lb & claimed_v;
        end
      end
      impd_pkg::REQ_SET_PEND: pend_next = pend | lb;
      impd_pkg::REQ_CLR_PEND: pend_next = pend & ~lb;
      impd_pkg::REQ_MASK:     mask_next = mask | lb;
      impd_pkg::REQ_UNMASK:   mask_next = mask & ~lb;
      impd_pkg::REQ_CLR_ALL:  pend_next = '0;
      impd_pkg::REQ_GDISABLE: gen_next  = 1'b0;
      impd_pkg::REQ_GENABLE:  gen_next  = 1'b1;
      default: ;
    endcase
    // While globally enabled, a scan clears every pending unmasked line; claimed ones are dispatched
    if (head.cmd.scan && gen_next) begin
      hit       = pend_next & ~mask_next;
      pend_next = pend_next & ~hit;
      disp_next = hit & claimed_v;
    end
  end

  assign pend_lo = impd_pkg::lowest_set(64'(pend_next));

  // Emit one dispatch per cycle, lowest line first
  assign lo      = impd_pkg::lowest_set(64'(rem));
  assign rem_clr = rem & (rem - LINE_COUNT'(1));

  assign done              = (state == S_EMIT);
  assign dispatch_valid    = done && (rem != '0);
  assign dispatched_line   = lo[4:0];
  assign last              = done && (rem_clr == '0);
  assign pending_any       = st_pany;
  assign next_pending_line = st_next;
  assign line_enabled      = st_len;
  assign global_enabled    = gen;

  assign load = head.valid && (state == S_IDLE || last);
  assign pop  = load;

  // Apply a command and hold its results until the run ends
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      mask    <= '1;
      pend    <= '0;
      gen     <= 1'b1;
      rem     <= '0;
      st_pany <= 1'b0;
      st_next <= '0;
      st_len  <= 1'b0;
    end else if (load) begin
      state   <= S_EMIT;
      mask    <= mask_next;
      pend    <= pend_next;
      gen     <= gen_next;
      rem     <= disp_next;
      st_pany <= (pend_next != '0);
      st_next <= pend_lo[4:0];
      st_len  <= (lb != '0) && ((mask_next & lb) == '0);
    end else if (state == S_EMIT) begin
      rem <= rem_clr;
      if (last) state <= S_IDLE;
    end
  end

  `IMPD_ASSERT_NOW(a_disp_claimed, clk, rst, dispatch_valid, claimed_lines[dispatched_line], "dispatch of unclaimed line")
  `IMPD_ASSERT_NOW(a_nodisp_last, clk, rst, done && !dispatch_valid, last, "empty result not last")
  `IMPD_ASSERT_NEXT(a_run_continues, clk, rst, done && !last, done && dispatch_valid, "dispatch run broken")

endmodule

`default_nettype wire

FILE: rtl/interrupt_mask_pending_dispatcher_unit.sv
// Channel   Handshake               Ports
// --------  ----------------------  ---------------------------------------------
// request   start & !busy           req_type, line
// result    done (one cycle)        dispatch_valid, dispatched_line, pending_any,
//                                   next_pending_line, line_enabled,
//                                   global_enabled, last
// config    claimed_lines_we        claimed_lines_wdata
//
// A request word enters a two-word queue; the back end takes it when idle or on the last word of a run.
// A request without dispatches yields one result word; a run of N dispatches
// yields N result words on consecutive cycles. Sustained: one request per cycle
// while no request dispatches more than one line.
// busy rises only while the queue is full, i.e. when requests keep arriving
// behind a run of two or more dispatches.
// rst is synchronous: all lines masked, nothing pending, global enable on.
// The receiver cannot stall; results are dropped if not taken.
`default_nettype none

module interrupt_mask_pending_dispatcher_unit #(
  parameter int LINE_COUNT = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  req_type,
  input  wire logic [4:0]  line,
  input  wire logic        claimed_lines_we,
  input  wire logic [31:0] claimed_lines_wdata,
  output logic             done,
  output logic             dispatch_valid,
  output logic [4:0]       dispatched_line,
  output logic             pending_any,
  output logic [4:0]       next_pending_line,
  output logic             line_enabled,
  output logic             global_enabled,
  output logic             last
);

  logic [31:0]        claimed_lines;
  impd_pkg::q_head_t  head;
  logic               pop;

  // Hold the claim register
  always_ff @(posedge clk) begin
    if (rst) begin
      claimed_lines <= '0;
    end else if (claimed_lines_we) begin
      claimed_lines <= claimed_lines_wdata;
    end
  end

  impd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .line     (line),
    .pop      (pop),
    .busy     (busy),
    .head     (head)
  );

  impd_back #(
    .LINE_COUNT (LINE_COUNT)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .claimed_lines     (claimed_lines),
    .head              (head),
    .pop               (pop),
    .done              (done),
    .dispatch_valid    (dispatch_valid),
    .dispatched_line   (dispatched_line),
    .pending_any       (pending_any),
    .next_pending_line (next_pending_line),
    .line_enabled      (line_enabled),
    .global_enabled    (global_enabled),
    .last              (last)
  );

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`default_nettype none

module tb_top;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic [3:0] req;
    logic [4:0] ln;
  } request_t;

  typedef struct {
    logic       dispatch_valid;
    logic [4:0] dispatched_line;
    logic       pending_any;
    logic [4:0] next_pending_line;
    logic       line_enabled;
    logic       global_enabled;
    logic       last;
  } result_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  req_type = impd_pkg::REQ_STATUS;
  logic [4:0]  line = '0;
  logic        claimed_lines_we = 1'b0;
  logic [31:0] claimed_lines_wdata = '0;
  logic        done;
  logic        dispatch_valid;
  logic [4:0]  dispatched_line;
  logic        pending_any;
  logic [4:0]  next_pending_line;
  logic        line_enabled;
  logic        global_enabled;
  logic        last;

  // Shadow state of the controller
  logic [31:0] line_mask = '1;
  logic [31:0] line_pending = '0;
  logic        global_on = 1'b1;
  logic [31:0] claimed_copy = '0;

  request_t     pending_items[$];
  result_word_t expected_words[$];
  int           failures = 0;
  int           accepted_count = 0;
  int           gap_left = 0;
  int           stall_cycles = 0;

  interrupt_mask_pending_dispatcher_unit dut (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .req_type            (req_type),
    .line                (line),
    .claimed_lines_we    (claimed_lines_we),
    .claimed_lines_wdata (claimed_lines_wdata),
    .done                (done),
    .dispatch_valid      (dispatch_valid),
    .dispatched_line     (dispatched_line),
    .pending_any         (pending_any),
    .next_pending_line   (next_pending_line),
    .line_enabled        (line_enabled),
    .global_enabled      (global_enabled),
    .last                (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one request to the shadow state and queue the words it produces
  task automatic resolve_request(input logic [3:0] req, input logic [4:0] ln);
    logic [31:0]  sel;
    logic [4:0]   hits[$];
    logic [4:0]   lowest;
    logic         do_scan;
    result_word_t w;
    sel = 32'd1 << ln;
    do_scan = 1'b0;
    hits = {};
    case (req)
      impd_pkg::REQ_RAISE: begin
        if ((line_pending & sel) == '0) begin
          if ((line_mask & sel) != '0 || !global_on) begin
            line_pending |= sel;
          end else if (claimed_copy[ln]) begin
            hits.push_back(ln);
          end
        end
      end
      impd_pkg::REQ_SET_PEND: begin
        line_pending |= sel;
        do_scan = 1'b1;
      end
      impd_pkg::REQ_CLR_PEND: line_pending &= ~sel;
      impd_pkg::REQ_MASK:     line_mask |= sel;
      impd_pkg::REQ_UNMASK: begin
        line_mask &= ~sel;
        do_scan = 1'b1;
      end
      impd_pkg::REQ_CLR_ALL:  line_pending = '0;
      impd_pkg::REQ_GDISABLE: global_on = 1'b0;
      impd_pkg::REQ_GENABLE: begin
        global_on = 1'b1;
        do_scan = 1'b1;
      end
      default: ;
    endcase

    // Walk pending, unmasked lines in ascending order
    if (do_scan && global_on) begin
      for (int i = 0; i < 32; i++) begin
        if (line_pending[i] && !line_mask[i]) begin
          line_pending[i] = 1'b0;
          if (claimed_copy[i]) hits.push_back(5'(i));
        end
      end
    end

    lowest = '0;
    for (int i = 31; i >= 0; i--) begin
      if (line_pending[i]) lowest = 5'(i);
    end

    w.pending_any = |line_pending;
    w.next_pending_line = lowest;
    w.line_enabled = !line_mask[ln];
    w.global_enabled = global_on;
    if (hits.size() == 0) begin
      w.dispatch_valid = 1'b0;
      w.dispatched_line = '0;
      w.last = 1'b1;
      expected_words.push_back(w);
    end else begin
      foreach (hits[k]) begin
        w.dispatch_valid = 1'b1;
        w.dispatched_line = hits[k];
        w.last = (k == hits.size() - 1);
        expected_words.push_back(w);
      end
    end
  endtask

  // Driver: present queued requests, with random gaps outside a quiet window
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      req_type <= impd_pkg::REQ_STATUS;
      line <= '0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        resolve_request(req_type, line);
        accepted_count++;
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() != 0 &&
                     ((accepted_count >= 90 && accepted_count < 150) ||
                      $urandom_range(0, 99) >= 5)) begin
          req_type <= pending_items[0].req;
          line <= pending_items[0].ln;
          void'(pending_items.pop_front());
          start <= 1'b1;
        end else if (pending_items.size() != 0) begin
          gap_left = $urandom_range(0, 3);
          start <= 1'b0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      failures++;
    end
  endfunction

  // Monitor: compare each result word against the oldest expectation
  always @(posedge clk) begin
    result_word_t w;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: line %0d", dispatched_line);
        failures++;
      end else begin
        w = expected_words.pop_front();
        check_field("dispatch_valid", w.dispatch_valid, dispatch_valid);
        check_field("dispatched_line", w.dispatched_line, dispatched_line);
        check_field("pending_any", w.pending_any, pending_any);
        check_field("next_pending_line", w.next_pending_line, next_pending_line);
        check_field("line_enabled", w.line_enabled, line_enabled);
        check_field("global_enabled", w.global_enabled, global_enabled);
        check_field("last", w.last, last);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || (done && expected_words.size() != 0) ||
        claimed_lines_we) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[interrupt_mask_pending_dispatcher_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic queue_request(input logic [3:0] req, input logic [4:0] ln);
    request_t r;
    r.req = req;
    r.ln = ln;
    pending_items.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_words.size() != 0 || start || gap_left != 0)
      @(negedge clk);
  endtask

  // Write the claim register; only called with the block idle
  task automatic write_claims(input logic [31:0] value);
    @(posedge clk);
    claimed_lines_we <= 1'b1;
    claimed_lines_wdata <= value;
    claimed_copy = value;
    @(posedge clk);
    claimed_lines_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [3:0] pick_request();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return impd_pkg::REQ_RAISE;
    if (roll < 45) return impd_pkg::REQ_SET_PEND;
    if (roll < 50) return impd_pkg::REQ_CLR_PEND;
    if (roll < 60) return impd_pkg::REQ_MASK;
    if (roll < 72) return impd_pkg::REQ_UNMASK;
    if (roll < 75) return impd_pkg::REQ_CLR_ALL;
    if (roll < 83) return impd_pkg::REQ_GDISABLE;
    if (roll < 91) return impd_pkg::REQ_GENABLE;
    if (roll < 95) return impd_pkg::REQ_STATUS;
    return 4'($urandom_range(9, 15));
  endfunction

  // Mix single requests with disable / pend / enable bursts
  task automatic queue_random(input int count);
    int n;
    int k;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(2, 8);
        queue_request(impd_pkg::REQ_GDISABLE, 5'($urandom_range(0, 31)));
        repeat (k) begin
          queue_request($urandom_range(0, 1) ? impd_pkg::REQ_RAISE : impd_pkg::REQ_SET_PEND,
                        5'($urandom_range(0, 31)));
        end
        if ($urandom_range(0, 1)) begin
          queue_request(impd_pkg::REQ_UNMASK, 5'($urandom_range(0, 31)));
        end
        queue_request(impd_pkg::REQ_GENABLE, 5'($urandom_range(0, 31)));
        n += k + 3;
      end else begin
        queue_request(pick_request(), 5'($urandom_range(0, 31)));
        n++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: every request kind, line extremes, special cases
    write_claims('1);
    queue_request(impd_pkg::REQ_STATUS, 5'd0);
    queue_request(impd_pkg::REQ_RAISE, 5'd0);
    queue_request(impd_pkg::REQ_RAISE, 5'd0);
    queue_request(impd_pkg::REQ_RAISE, 5'd31);
    queue_request(impd_pkg::REQ_UNMASK, 5'd0);
    queue_request(impd_pkg::REQ_UNMASK, 5'd31);
    queue_request(impd_pkg::REQ_RAISE, 5'd31);
    queue_request(impd_pkg::REQ_GDISABLE, 5'd3);
    queue_request(impd_pkg::REQ_GDISABLE, 5'd3);
    queue_request(impd_pkg::REQ_RAISE, 5'd31);
    queue_request(impd_pkg::REQ_SET_PEND, 5'd0);
    queue_request(impd_pkg::REQ_GENABLE, 5'd0);
    queue_request(impd_pkg::REQ_GENABLE, 5'd0);
    queue_request(impd_pkg::REQ_MASK, 5'd31);
    queue_request(impd_pkg::REQ_SET_PEND, 5'd31);
    queue_request(impd_pkg::REQ_CLR_PEND, 5'd31);
    queue_request(impd_pkg::REQ_SET_PEND, 5'd5);
    queue_request(impd_pkg::REQ_RAISE, 5'd7);
    queue_request(impd_pkg::REQ_CLR_ALL, 5'd0);
    queue_request(4'd9, 5'd15);
    queue_request(4'd15, 5'd31);
    wait_idle();

    // Odd lines unclaimed: raises and scans consume them without dispatch
    write_claims(32'h5555_5555);
    queue_request(impd_pkg::REQ_UNMASK, 5'd1);
    queue_request(impd_pkg::REQ_RAISE, 5'd1);
    queue_request(impd_pkg::REQ_UNMASK, 5'd2);
    queue_request(impd_pkg::REQ_RAISE, 5'd2);
    queue_random(30);
    wait_idle();

    // Full run: every line pended at once, then released together
    write_claims('1);
    for (int i = 0; i < 32; i++) queue_request(impd_pkg::REQ_UNMASK, 5'(i));
    queue_request(impd_pkg::REQ_GDISABLE, 5'd0);
    for (int i = 0; i < 32; i++) queue_request(impd_pkg::REQ_SET_PEND, 5'(i));
    queue_request(impd_pkg::REQ_GENABLE, 5'd0);
    queue_random(10);
    wait_idle();

    write_claims('0);
    queue_random(25);
    wait_idle();

    write_claims($urandom);
    queue_random(30);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("[interrupt_mask_pending_dispatcher_unit] OK");
    end else begin
      $display("[interrupt_mask_pending_dispatcher_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
